@@ hdl/lgir_pkg.sv @@
`timescale 1ns / 1ps

package lgir_pkg;

	// Field widths
	localparam int unsigned DUR_W  = 16;
	localparam int unsigned CODE_W = 32;
	localparam int unsigned BITS_W = 6;
	localparam int unsigned TOL_W  = 7;

	// Register map, word index taken from paddr[3:2]
	localparam int unsigned ADDR_W = 4;
	typedef enum logic [1:0] {
		REG_TOLERANCE = 2'd0,
		REG_EXP_CODE  = 2'd1,
		REG_EXP_BITS  = 2'd2,
		REG_UNUSED    = 2'd3
	} reg_idx_t;

	// Register reset values
	localparam logic [TOL_W-1:0]  TOL_RESET       = 7'd25;
	localparam logic [TOL_W-1:0]  TOL_MAX         = 7'd100;
	localparam logic [CODE_W-1:0] EXP_CODE_RESET  = 32'd0;
	localparam logic [BITS_W-1:0] EXP_BITS_RESET  = 6'd32;

	// Frame lengths
	localparam logic [BITS_W-1:0] SHORT_FRAME = 6'd28;
	localparam logic [BITS_W-1:0] FULL_FRAME  = 6'd32;

	// Timing windows, one per nominal duration
	localparam int unsigned NUM_WIN = 5;
	localparam int unsigned WIN_HDR_MARK   = 0;
	localparam int unsigned WIN_HDR_SPACE  = 1;
	localparam int unsigned WIN_BIT_MARK   = 2;
	localparam int unsigned WIN_ONE_SPACE  = 3;
	localparam int unsigned WIN_ZERO_SPACE = 4;

	localparam int unsigned NOM_W = 14;
	localparam logic [NOM_W-1:0] NOMINAL [NUM_WIN] = '{
		14'd8000, 14'd4000, 14'd600, 14'd1600, 14'd550
	};

	// Scaled nominal (percent * nominal) fits 21 bits: 200 * 8000 < 2**21
	localparam int unsigned PCT_W  = 8;
	localparam int unsigned PROD_W = 21;
	// floor(x / 100) == (x * RECIP) >> RECIP_SHIFT for every x below 1.86e6
	localparam logic [PROD_W-1:0] RECIP       = 21'd1342178;
	localparam int unsigned       RECIP_SHIFT = 27;

	typedef logic [PROD_W-1:0] prod_t;
	typedef logic [DUR_W-1:0]  bound_t;

	typedef struct packed {
		bound_t lo;
		bound_t hi;
	} window_t;

	// Percent times nominal duration
	function automatic prod_t scale_nom(logic [PCT_W-1:0] pct, logic [NOM_W-1:0] nom);
		logic [PROD_W-1:0] a;
		logic [PROD_W-1:0] b;
		a = {{(PROD_W-PCT_W){1'b0}}, pct};
		b = {{(PROD_W-NOM_W){1'b0}}, nom};
		return PROD_W'(a * b);
	endfunction

	// Divide a scaled duration by one hundred through the reciprocal
	function automatic bound_t div100(prod_t p);
		logic [2*PROD_W-1:0] full;
		full = {{PROD_W{1'b0}}, p} * {{PROD_W{1'b0}}, RECIP};
		return DUR_W'(full >> RECIP_SHIFT);
	endfunction

	// Measured duration inside an inclusive window
	function automatic logic in_window(logic [DUR_W-1:0] d, window_t w);
		return (d >= w.lo) && (d <= w.hi);
	endfunction

endpackage

@@ hdl/lgir_pair_if.sv @@
`timescale 1ns / 1ps

interface lgir_pair_if;
	logic        valid;
	logic        ready;
	logic [15:0] mark_us;
	logic [15:0] space_us;
	logic        burst_start;

	modport source (output valid, output mark_us, output space_us, output burst_start,
		input ready);
	modport sink (input valid, input mark_us, input space_us, input burst_start,
		output ready);
endinterface

@@ hdl/lgir_result_if.sv @@
`timescale 1ns / 1ps

interface lgir_result_if;
	logic        valid;
	logic        ready;
	logic        frame_ok;
	logic [31:0] received_code;
	logic [5:0]  received_bits;
	logic        code_matches;

	modport source (output valid, output frame_ok, output received_code,
		output received_bits, output code_matches, input ready);
	modport sink (input valid, input frame_ok, input received_code,
		input received_bits, input code_matches, output ready);
endinterface

@@ hdl/lg_ir_frame_decoder.sv @@
`timescale 1ns / 1ps

// LG infrared frame decoder.
// pairs:   one mark/space duration pair per transfer; burst_start flags the
//          header pair of a new burst and restarts decoding.
// results: one transfer per finished frame or rejected header, carrying
//          frame_ok, received_code, received_bits and code_matches.
// APB:     tolerance_pct at 0x0, expected_code at 0x4, expected_bits at 0x8;
//          pready is tied high, writes complete in the access cycle.
// Path:    a pair is captured in the input register and, once the result slot
//          is free or being emptied, decoded into the result register, from
//          which the result is offered.
// Throughput: one pair per cycle unless a result waits untaken; a decode is a
//          single pass of window compares and a shift, and the output register
//          frees its slot in the same cycle the sink takes the pending result.
// Reset:   tolerance 25 percent, expected code 0, expected bits 32, decoder
//          idle and waiting for a burst start, no result pending.
// Stall:   while a result waits, the input register holds one pair and then
//          pairs.ready drops until the sink takes the result.
// On a tolerance write the scaled nominals are registered first and the
// windows from them after that, so a pair right after a write may see old ones.

module lg_ir_frame_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	lgir_pair_if.sink            pairs,
	lgir_result_if.source        results
);
	import lgir_pkg::*;

	typedef enum logic {
		PH_IDLE,
		PH_DECODE
	} phase_t;

	// Configuration registers
	logic [TOL_W-1:0]  tol_q;
	logic [CODE_W-1:0] exp_code_q;
	logic [BITS_W-1:0] exp_bits_q;

	// Scaled nominals and the resulting windows
	prod_t   prod_lo_q [NUM_WIN];
	prod_t   prod_hi_q [NUM_WIN];
	window_t win_q     [NUM_WIN];

	logic              cfg_wr;
	reg_idx_t          cfg_idx;
	logic [TOL_W-1:0]  tol_clamp;
	logic [PCT_W-1:0]  pct_lo;
	logic [PCT_W-1:0]  pct_hi;

	// Input register
	logic              valid_s1;
	logic [DUR_W-1:0]  mark_s1;
	logic [DUR_W-1:0]  space_s1;
	logic              start_s1;

	// Decoder state
	phase_t            phase_q;
	logic [CODE_W-1:0] shift_q;
	logic [BITS_W-1:0] count_q;

	// Result register
	logic              out_valid_q;
	logic              ok_q;
	logic [CODE_W-1:0] code_q;
	logic [BITS_W-1:0] bits_q;
	logic              match_q;

	// Next-state values
	phase_t            phase_d;
	logic [CODE_W-1:0] shift_d;
	logic [BITS_W-1:0] count_d;
	logic              emit;
	logic              ok_d;
	logic [CODE_W-1:0] code_d;
	logic [BITS_W-1:0] bits_d;
	logic              match_d;

	logic              hdr_hit;
	logic              one_hit;
	logic              zero_hit;
	logic              advance;
	logic              in_ready;

	// APB decode
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[3:2]);

	always_comb begin
		unique case (cfg_idx)
			REG_TOLERANCE: prdata = {{(32-TOL_W){1'b0}}, tol_q};
			REG_EXP_CODE:  prdata = exp_code_q;
			REG_EXP_BITS:  prdata = {{(32-BITS_W){1'b0}}, exp_bits_q};
			default:       prdata = 32'd0;
		endcase
	end

	// Clamp the tolerance and form the two percent factors
	assign tol_clamp = (pwdata[TOL_W-1:0] > TOL_MAX) ? TOL_MAX : pwdata[TOL_W-1:0];
	assign pct_lo    = {1'b0, TOL_MAX} - {1'b0, tol_clamp};
	assign pct_hi    = {1'b0, TOL_MAX} + {1'b0, tol_clamp};

	// Hold configuration, scale nominals on a tolerance write, then divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q      <= TOL_RESET;
			exp_code_q <= EXP_CODE_RESET;
			exp_bits_q <= EXP_BITS_RESET;
			for (int i = 0; i < NUM_WIN; i++) begin
				prod_lo_q[i] <= scale_nom(PCT_W'(TOL_MAX - TOL_RESET), NOMINAL[i]);
				prod_hi_q[i] <= scale_nom(PCT_W'(TOL_MAX + TOL_RESET), NOMINAL[i]);
				win_q[i].lo  <= div100(scale_nom(PCT_W'(TOL_MAX - TOL_RESET), NOMINAL[i]));
				win_q[i].hi  <= div100(scale_nom(PCT_W'(TOL_MAX + TOL_RESET), NOMINAL[i]));
			end
		end else begin
			if (cfg_wr) begin
				unique case (cfg_idx)
					REG_TOLERANCE: begin
						tol_q <= pwdata[TOL_W-1:0];
						for (int i = 0; i < NUM_WIN; i++) begin
							prod_lo_q[i] <= scale_nom(pct_lo, NOMINAL[i]);
							prod_hi_q[i] <= scale_nom(pct_hi, NOMINAL[i]);
						end
					end
					REG_EXP_CODE: exp_code_q <= pwdata[CODE_W-1:0];
					REG_EXP_BITS: exp_bits_q <= pwdata[BITS_W-1:0];
					default: ;
				endcase
			end
			for (int i = 0; i < NUM_WIN; i++) begin
				win_q[i].lo <= div100(prod_lo_q[i]);
				win_q[i].hi <= div100(prod_hi_q[i]);
			end
		end
	end

	// Handshake: decode a pair when the result slot is free or being emptied
	assign advance      = valid_s1 && (!out_valid_q || results.ready);
	assign in_ready     = !valid_s1 || advance;
	assign pairs.ready  = in_ready;

	// Capture incoming pairs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= pairs.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && pairs.valid) begin
			mark_s1  <= pairs.mark_us;
			space_s1 <= pairs.space_us;
			start_s1 <= pairs.burst_start;
		end
	end

	// Classify the pair
	assign hdr_hit  = in_window(mark_s1, win_q[WIN_HDR_MARK])
		&& in_window(space_s1, win_q[WIN_HDR_SPACE]);
	assign one_hit  = in_window(mark_s1, win_q[WIN_BIT_MARK])
		&& in_window(space_s1, win_q[WIN_ONE_SPACE]);
	assign zero_hit = in_window(mark_s1, win_q[WIN_BIT_MARK])
		&& in_window(space_s1, win_q[WIN_ZERO_SPACE]);

	// Decode step: header check, shift a bit, or close the frame
	always_comb begin
		phase_d = phase_q;
		shift_d = shift_q;
		count_d = count_q;
		emit    = 1'b0;
		ok_d    = 1'b0;
		code_d  = shift_q;
		bits_d  = count_q;
		if (start_s1) begin
			shift_d = '0;
			count_d = '0;
			if (hdr_hit) begin
				phase_d = PH_DECODE;
			end else begin
				phase_d = PH_IDLE;
				emit    = 1'b1;
				code_d  = '0;
				bits_d  = '0;
			end
		end else if (phase_q == PH_DECODE) begin
			if (one_hit || zero_hit) begin
				shift_d = {shift_q[CODE_W-2:0], one_hit};
				count_d = count_q + 1'b1;
				if (count_d >= FULL_FRAME) begin
					phase_d = PH_IDLE;
					emit    = 1'b1;
					ok_d    = 1'b1;
					code_d  = shift_d;
					bits_d  = count_d;
				end
			end else begin
				phase_d = PH_IDLE;
				emit    = 1'b1;
				ok_d    = (count_q == SHORT_FRAME);
			end
		end
		match_d = ok_d && (code_d == exp_code_q) && (bits_d == exp_bits_q);
	end

	// Decoder state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			shift_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q     <= phase_d;
				shift_q     <= shift_d;
				count_q     <= count_d;
				out_valid_q <= emit;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			ok_q    <= ok_d;
			code_q  <= code_d;
			bits_q  <= bits_d;
			match_q <= match_d;
		end
	end

	assign results.valid         = out_valid_q;
	assign results.frame_ok      = ok_q;
	assign results.received_code = code_q;
	assign results.received_bits = bits_q;
	assign results.code_matches  = match_q;

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import lgir_pkg::*;

	localparam int unsigned PCT_BASE      = 100;
	localparam int unsigned IDLE_PCT      = 16;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned SETTLE_CYCLES = 6;
	localparam int unsigned ITEM_TARGET   = 650;
	localparam int unsigned FRAMES_PER_SET = 6;

	localparam int unsigned HDR_MARK   = NOMINAL[WIN_HDR_MARK];
	localparam int unsigned HDR_SPACE  = NOMINAL[WIN_HDR_SPACE];
	localparam int unsigned BIT_MARK   = NOMINAL[WIN_BIT_MARK];
	localparam int unsigned ONE_SPACE  = NOMINAL[WIN_ONE_SPACE];
	localparam int unsigned ZERO_SPACE = NOMINAL[WIN_ZERO_SPACE];

	typedef struct packed {
		logic              ok;
		logic [CODE_W-1:0] code;
		logic [BITS_W-1:0] bits;
		logic              match;
	} frame_rec_t;

	// Tracks the decoder state and holds the frame reports still to come
	class frame_scoreboard;
		logic [TOL_W-1:0]  tol;
		logic [CODE_W-1:0] want_code;
		logic [BITS_W-1:0] want_bits;
		bit                decoding;
		logic [CODE_W-1:0] shift_code;
		logic [BITS_W-1:0] taken;
		frame_rec_t        pending[$];
		int unsigned       errors;

		function new();
			tol        = TOL_RESET;
			want_code  = EXP_CODE_RESET;
			want_bits  = EXP_BITS_RESET;
			decoding   = 1'b0;
			shift_code = '0;
			taken      = '0;
			errors     = 0;
		endfunction

		function void write_reg(reg_idx_t idx, logic [31:0] value);
			case (idx)
				REG_TOLERANCE: tol = value[TOL_W-1:0];
				REG_EXP_CODE:  want_code = value;
				REG_EXP_BITS:  want_bits = value[BITS_W-1:0];
				default: ;
			endcase
		endfunction

		// Inclusive window around a nominal duration, tolerance clamped at 100
		function bit near(int unsigned d, int unsigned nom);
			int unsigned t;
			int unsigned lo;
			int unsigned hi;
			t  = (tol > TOL_MAX) ? TOL_MAX : tol;
			lo = (PCT_BASE - t) * nom / PCT_BASE;
			hi = (PCT_BASE + t) * nom / PCT_BASE;
			return (d >= lo) && (d <= hi);
		endfunction

		function void close_frame(bit ok);
			frame_rec_t f;
			f.ok    = ok;
			f.code  = shift_code;
			f.bits  = taken;
			f.match = ok && (shift_code == want_code) && (taken == want_bits);
			pending.push_back(f);
			decoding = 1'b0;
		endfunction

		// Advance the decoder by one pair; return 0 when the pair is ignored
		function bit note_pair(logic [15:0] mark, logic [15:0] space, logic start);
			if (start) begin
				shift_code = '0;
				taken      = '0;
				if (near(mark, HDR_MARK) && near(space, HDR_SPACE))
					decoding = 1'b1;
				else
					close_frame(1'b0);
				return 1'b1;
			end
			if (!decoding)
				return 1'b0;
			if (near(mark, BIT_MARK) && near(space, ONE_SPACE)) begin
				shift_code = {shift_code[CODE_W-2:0], 1'b1};
			end else if (near(mark, BIT_MARK) && near(space, ZERO_SPACE)) begin
				shift_code = {shift_code[CODE_W-2:0], 1'b0};
			end else begin
				close_frame(taken == SHORT_FRAME);
				return 1'b1;
			end
			taken++;
			if (taken >= FULL_FRAME)
				close_frame(1'b1);
			return 1'b1;
		endfunction

		function void check_frame(logic ok, logic [31:0] code, logic [5:0] bits, logic match);
			frame_rec_t f;
			if (pending.size() == 0) begin
				$display("%0t: unexpected frame report ok %0d code %h bits %0d match %0d",
					$time, ok, code, bits, match);
				errors++;
				return;
			end
			f = pending.pop_front();
			if (ok !== f.ok) begin
				$display("%0t: frame_ok expected %0d actual %0d", $time, f.ok, ok);
				errors++;
			end
			if (code !== f.code) begin
				$display("%0t: received_code expected %h actual %h", $time, f.code, code);
				errors++;
			end
			if (bits !== f.bits) begin
				$display("%0t: received_bits expected %0d actual %0d", $time, f.bits, bits);
				errors++;
			end
			if (match !== f.match) begin
				$display("%0t: code_matches expected %0d actual %0d", $time, f.match, match);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	lgir_pair_if   pairs_if ();
	lgir_result_if res_if ();

	frame_scoreboard tracker = new();

	bit          no_idle = 1'b0;
	bit          hold_req = 1'b0;
	int unsigned hold_left = 0;
	int unsigned pairs_sent = 0;

	lg_ir_frame_decoder DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pairs   (pairs_if),
		.results (res_if)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hard stop in case the decoder hangs
	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	// Duration inside the current window, at its edges, or just outside on request
	function automatic logic [15:0] pick_dur(int unsigned nom, bit miss);
		int unsigned t;
		int unsigned lo;
		int unsigned hi;
		int unsigned r;
		t  = (tracker.tol > TOL_MAX) ? TOL_MAX : tracker.tol;
		lo = (PCT_BASE - t) * nom / PCT_BASE;
		hi = (PCT_BASE + t) * nom / PCT_BASE;
		if (miss)
			return (lo > 0 && $urandom_range(1) == 1) ? 16'(lo - 1) : 16'(hi + 1);
		r = $urandom_range(9);
		if (r < 2)
			return 16'(lo);
		if (r < 4)
			return 16'(hi);
		if (r < 5)
			return 16'(nom);
		return 16'($urandom_range(hi, lo));
	endfunction

	task automatic send_pair(logic [15:0] mark, logic [15:0] space, logic start);
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			pairs_if.valid <= 1'b0;
			@(posedge clk);
		end
		pairs_if.valid       <= 1'b1;
		pairs_if.mark_us     <= mark;
		pairs_if.space_us    <= space;
		pairs_if.burst_start <= start;
		do @(posedge clk); while (!pairs_if.ready);
		if (tracker.note_pair(mark, space, start))
			pairs_sent++;
	endtask

	// Drop valid and wait until every frame report has been taken
	task automatic drain();
		pairs_if.valid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		tracker.write_reg(idx, value);
	endtask

	// Header, nbits data pairs MSB first, then an optional end marker
	task automatic send_frame(logic [31:0] code, int unsigned nbits);
		int unsigned i;
		int unsigned r;
		logic        b;
		send_pair(pick_dur(HDR_MARK, $urandom_range(29) == 0),
			pick_dur(HDR_SPACE, $urandom_range(29) == 0), 1'b1);
		for (i = 0; i < nbits; i++) begin
			b = code[nbits-1-i];
			send_pair(pick_dur(BIT_MARK, $urandom_range(199) == 0),
				pick_dur(b ? ONE_SPACE : ZERO_SPACE, $urandom_range(199) == 0), 1'b0);
		end
		r = $urandom_range(9);
		if (nbits < FULL_FRAME && r < 6)
			send_pair(16'($urandom), (r == 0) ? 16'hFFFF : 16'($urandom_range(65535, 3300)),
				1'b0);
		else if (r == 9)
			send_pair(16'($urandom), 16'($urandom), 1'($urandom_range(1)));
	endtask

	// Result side: check each transfer, then pick ready for the next cycle
	initial begin
		res_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_if.valid && res_if.ready)
				tracker.check_frame(res_if.frame_ok, res_if.received_code,
					res_if.received_bits, res_if.code_matches);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_if.ready <= 1'b0;
			end else begin
				res_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin
		int unsigned      set_no;
		int unsigned      r;
		int unsigned      nbits;
		logic [TOL_W-1:0] tol_val;
		logic [5:0]       bits_val;
		logic [31:0]      set_code;
		logic [31:0]      want;

		arst_n               <= 1'b0;
		psel                 <= 1'b0;
		penable              <= 1'b0;
		pwrite               <= 1'b0;
		paddr                <= '0;
		pwdata               <= '0;
		pairs_if.valid       <= 1'b0;
		pairs_if.mark_us     <= '0;
		pairs_if.space_us    <= '0;
		pairs_if.burst_start <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset tolerance of 25 percent
		send_pair(16'd600, 16'd1600, 1'b0);
		send_pair(16'd0, 16'd0, 1'b1);
		send_pair(16'hFFFF, 16'hFFFF, 1'b1);
		send_pair(16'd8000, 16'd4000, 1'b1);
		send_pair(16'd8000, 16'd4000, 1'b1);
		send_pair(16'd600, 16'd1600, 1'b0);
		send_pair(16'd600, 16'd550, 1'b0);
		// restart in the middle of a frame, header at the lower edges
		send_pair(16'd6000, 16'd3000, 1'b1);
		send_pair(16'd750, 16'd2000, 1'b0);
		send_pair(16'd450, 16'd412, 1'b0);
		send_pair(16'd601, 16'hFFFF, 1'b0);
		send_pair(16'd10000, 16'd5000, 1'b1);
		send_pair(16'd10001, 16'd5000, 1'b1);

		// Full tolerance: windows overlap and reach down to zero
		drain();
		apb_write(REG_TOLERANCE, 32'(TOL_MAX));
		send_pair(16'd8000, 16'd4000, 1'b1);
		send_pair(16'd600, 16'd550, 1'b0);
		send_pair(16'd0, 16'd0, 1'b0);
		send_pair(16'hFFFF, 16'd0, 1'b0);

		// Tolerance above the clamp
		drain();
		apb_write(REG_TOLERANCE, 32'h7F);
		send_pair(16'd16000, 16'd8000, 1'b1);
		send_pair(16'd1201, 16'd0, 1'b0);

		// Zero tolerance: exact durations only
		drain();
		apb_write(REG_TOLERANCE, 32'd0);
		send_pair(16'd8000, 16'd4000, 1'b1);
		send_pair(16'd600, 16'd1600, 1'b0);
		send_pair(16'd600, 16'd1601, 1'b0);

		// Random frames, one register setting per set
		set_no = 0;
		while (pairs_sent < ITEM_TARGET) begin
			drain();
			case (set_no)
				0: begin tol_val = 7'd0;   bits_val = 6'd32; set_code = 32'hFFFF_FFFF; end
				1: begin tol_val = TOL_MAX; bits_val = 6'd28; set_code = 32'h0; end
				2: begin tol_val = 7'h7F;  bits_val = 6'h3F; set_code = $urandom; end
				3: begin tol_val = TOL_RESET; bits_val = 6'd0; set_code = $urandom; end
				default: begin
					r = $urandom_range(5);
					tol_val = (r == 0) ? 7'd0 : (r == 1) ? TOL_MAX :
						(r == 2) ? 7'($urandom_range(127, 101)) :
						(r == 3) ? TOL_RESET : 7'($urandom_range(99, 1));
					r = $urandom_range(9);
					bits_val = (r < 4) ? 6'd32 : (r < 7) ? 6'd28 : 6'($urandom_range(63));
					set_code = $urandom;
				end
			endcase
			want = (bits_val < 32) ? (set_code & ((32'd1 << bits_val) - 1)) : set_code;
			apb_write(REG_TOLERANCE, 32'(tol_val));
			apb_write(REG_EXP_CODE, want);
			apb_write(REG_EXP_BITS, 32'(bits_val));

			// one set under a long result stall, two with no idling at all
			if (set_no == 1)
				hold_req = 1'b1;
			no_idle = (set_no == 2 || set_no == 3);

			repeat (FRAMES_PER_SET) begin
				r = $urandom_range(9);
				if (r < 5)
					nbits = (bits_val <= 32) ? bits_val : 32;
				else if (r < 7)
					nbits = 32;
				else if (r == 7)
					nbits = 28;
				else
					nbits = $urandom_range(32);
				send_frame(($urandom_range(9) < 7) ? set_code : $urandom, nbits);
			end
			set_no++;
		end

		no_idle = 1'b0;
		drain();
		if (tracker.errors == 0 && tracker.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
